[sv/hbvs_pkg.sv]
// package for the byte histogram with vowel statistics
// holds widths, character codes, the sequencer state type and the vowel test
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hbvs_pkg;

    localparam int CNT_W     = 32;
    localparam int BIN_N     = 256;
    localparam int BIN_AW    = $clog2(BIN_N);
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int STEP_W    = $clog2(FRAC_BITS);

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_E_LO = 8'h65;
    localparam logic [7:0] CH_E_UP = 8'h45;
    localparam logic [7:0] CH_I_LO = 8'h69;
    localparam logic [7:0] CH_I_UP = 8'h49;
    localparam logic [7:0] CH_O_LO = 8'h6f;
    localparam logic [7:0] CH_O_UP = 8'h4f;
    localparam logic [7:0] CH_U_LO = 8'h75;
    localparam logic [7:0] CH_U_UP = 8'h55;
    localparam logic [7:0] CH_Y_LO = 8'h79;
    localparam logic [7:0] CH_Y_UP = 8'h59;

    localparam logic OP_LOG   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_PREP,
        S_DIV
    } t_state;

    function automatic logic is_plain_vowel(input logic [7:0] b);
        return b inside {CH_A_LO, CH_A_UP, CH_E_LO, CH_E_UP, CH_I_LO,
                         CH_I_UP, CH_O_LO, CH_O_UP, CH_U_LO, CH_U_UP};
    endfunction

    function automatic logic is_y_letter(input logic [7:0] b);
        return b inside {CH_Y_LO, CH_Y_UP};
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

[sv/hbvs_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module hbvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[sv/byte_histogram_vowel_stats.sv]
// byte histogram with running total, vowel counts and q1.16 vowel fraction
// depends on hbvs_pkg and hbvs_ram
//
// usage:
//   command channel: an item (i_op, i_byte_value) is taken at a clock edge
//   with start high and busy low. i_op = 0 logs the byte, i_op = 1 only
//   reads its bin. busy stays high until the result has been produced.
//   result channel: o_result_valid is high for one cycle with bin count,
//   total, vowel count and vowel fraction; the receiver cannot stall it.
//   config channel: i_cfg_valid / o_cfg_ready write include_y (i_cfg_data);
//   o_cfg_ready is always high. write it only while the block is idle.
// sequence:
//   the bin ram is read as the item is taken, then the counters are updated,
//   then the vowel sum is formed, then the shared restoring subtractor builds
//   the fraction one bit a cycle, unless the fraction saturates or the total
//   is zero. the result strobe comes as the block returns to idle, and a new
//   item can be taken in the strobe cycle.
// reset: synchronous active-low; bins read as zero through per-bin valid
//   flops, counters and include_y clear, no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module byte_histogram_vowel_stats
    import hbvs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output      logic              busy,
    input  wire logic              i_op,
    input  wire logic [7:0]        i_byte_value,
    input  wire logic              i_cfg_valid,
    output      logic              o_cfg_ready,
    input  wire logic              i_cfg_data,
    output      logic              o_result_valid,
    output      logic [CNT_W-1:0]  o_bin_count,
    output      logic [CNT_W-1:0]  o_total_count,
    output      logic [CNT_W-1:0]  o_vowel_count,
    output      logic [FRAC_W-1:0] o_vowel_fraction
);

    t_state r_state, n_state;

    logic                 r_include_y;
    logic                 r_op, n_op;
    logic [BIN_AW-1:0]    r_byte, n_byte;
    logic [BIN_N-1:0]     r_valid, n_valid;
    logic [CNT_W-1:0]     r_total, n_total;
    logic [CNT_W-1:0]     r_plain, n_plain;
    logic [CNT_W-1:0]     r_ylet, n_ylet;
    logic [CNT_W-1:0]     r_bin, n_bin;
    logic [CNT_W-1:0]     r_vowels, n_vowels;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [FRAC_BITS-1:0] r_quot, n_quot;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [FRAC_W-1:0]    r_frac, n_frac;
    logic                 r_out_valid, n_out_valid;

    logic                 ram_we;
    logic [BIN_AW-1:0]    ram_raddr;
    logic [CNT_W-1:0]     ram_rdata;
    logic [CNT_W-1:0]     bin_old;
    logic [CNT_W:0]       vsum;
    logic [CNT_W:0]       rem_sh;
    logic [CNT_W-1:0]     rem_diff;
    logic                 quot_bit;

    hbvs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BIN_N)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_byte),
        .i_wdata (n_bin),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_include_y <= 1'b0;
            r_valid     <= '0;
            r_total     <= '0;
            r_plain     <= '0;
            r_ylet      <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_total     <= n_total;
            r_plain     <= n_plain;
            r_ylet      <= n_ylet;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            if (i_cfg_valid && o_cfg_ready) begin
                r_include_y <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_byte   <= n_byte;
        r_bin    <= n_bin;
        r_vowels <= n_vowels;
        r_rem    <= n_rem;
        r_quot   <= n_quot;
        r_frac   <= n_frac;
    end

    // shared subtractor: one quotient bit per cycle
    // remainder stays below the total, so the difference fits the counter width
    assign rem_sh   = {r_rem, 1'b0};
    assign rem_diff = rem_sh[CNT_W-1:0] - r_total;
    assign quot_bit = (rem_sh >= {1'b0, r_total});

    assign bin_old  = r_valid[r_byte] ? ram_rdata : '0;
    assign vsum     = {1'b0, r_plain} + (r_include_y ? {1'b0, r_ylet} : '0);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_byte      = r_byte;
        n_valid     = r_valid;
        n_total     = r_total;
        n_plain     = r_plain;
        n_ylet      = r_ylet;
        n_bin       = r_bin;
        n_vowels    = r_vowels;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_step      = r_step;
        n_frac      = r_frac;
        n_out_valid = 1'b0;
        ram_we      = 1'b0;
        ram_raddr   = r_byte;

        case (r_state)
            S_IDLE: begin
                ram_raddr = i_byte_value;
                if (start) begin
                    n_op    = i_op;
                    n_byte  = i_byte_value;
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_bin = bin_old;
                if (r_op == OP_LOG) begin
                    n_bin            = sat_inc(bin_old);
                    ram_we           = 1'b1;
                    n_valid[r_byte]  = 1'b1;
                    n_total          = sat_inc(r_total);
                    if (is_plain_vowel(r_byte)) begin
                        n_plain = sat_inc(r_plain);
                    end else if (is_y_letter(r_byte)) begin
                        n_ylet = sat_inc(r_ylet);
                    end
                end
                n_state = S_PREP;
            end
            S_PREP: begin
                n_vowels = vsum[CNT_W] ? CNT_MAX : vsum[CNT_W-1:0];
                n_rem    = n_vowels;
                n_quot   = '0;
                n_step   = '0;
                if (r_total == '0) begin
                    n_frac      = '0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else if (n_vowels >= r_total) begin
                    n_frac      = FRAC_ONE;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = quot_bit ? rem_diff : rem_sh[CNT_W-1:0];
                n_quot = {r_quot[FRAC_BITS-2:0], quot_bit};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(FRAC_BITS - 1)) begin
                    n_frac      = {1'b0, n_quot};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy             = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_result_valid   = r_out_valid;
    assign o_bin_count      = r_bin;
    assign o_total_count    = r_total;
    assign o_vowel_count    = r_vowels;
    assign o_vowel_fraction = r_frac;

endmodule

`default_nettype wire

[sv/hbvs_chk.sv]
// port-level checker for byte_histogram_vowel_stats, bound to the top level
// depends on hbvs_pkg
`timescale 1ns / 1ps
`default_nettype none

module hbvs_chk
    import hbvs_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_result_valid,
    input wire logic [CNT_W-1:0]  o_total_count,
    input wire logic [CNT_W-1:0]  o_vowel_count,
    input wire logic [FRAC_W-1:0] o_vowel_fraction
);

    // an accepted beat must make the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // the strobe arrives as busy drops, never during the work
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy && $past(busy)))
        else $error("result strobe outside end of item");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_vowel_fraction <= FRAC_ONE))
        else $error("vowel fraction above one");

    a_frac_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_total_count == '0) |->
            (o_vowel_fraction == '0 && o_vowel_count == '0))
        else $error("nonzero vowels with empty log");

endmodule

bind byte_histogram_vowel_stats hbvs_chk u_hbvs_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_result_valid   (o_result_valid),
    .o_total_count    (o_total_count),
    .o_vowel_count    (o_vowel_count),
    .o_vowel_fraction (o_vowel_fraction)
);

`default_nettype wire

[dv/tb_top.sv]
// self-checking testbench for byte_histogram_vowel_stats
// needs hbvs_pkg and the block's rtl; drives directed rows, then random phases
`timescale 1ns / 1ps

module tb_top;
    import hbvs_pkg::*;

    typedef struct packed {
        logic [CNT_W-1:0]  bin;
        logic [CNT_W-1:0]  total;
        logic [CNT_W-1:0]  vowels;
        logic [FRAC_W-1:0] frac;
    } t_stats;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CHECKED,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic       op;
        logic [7:0] byte_val;
        logic       cfg_val;
        t_stats     typed;
    } t_dir_row;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 172;
    localparam int MAX_LATENCY = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic i_op = OP_LOG;
    logic [7:0] i_byte_value = 8'h00;
    logic i_cfg_valid = 1'b0;
    logic i_cfg_data = 1'b0;
    logic busy;
    logic o_cfg_ready;
    logic o_result_valid;
    logic [CNT_W-1:0] o_bin_count;
    logic [CNT_W-1:0] o_total_count;
    logic [CNT_W-1:0] o_vowel_count;
    logic [FRAC_W-1:0] o_vowel_fraction;

    // mirror of the histogram state
    logic [CNT_W-1:0] hist_bins [BIN_N];
    logic [CNT_W-1:0] hist_total;
    logic [CNT_W-1:0] hist_plain;
    logic [CNT_W-1:0] hist_ylet;
    logic             hist_incl_y;

    t_stats   pending_stats [$];
    t_dir_row dir_rows [$];
    logic [7:0] vowel_chars [12];

    int mismatch_cnt = 0;
    int error_cnt = 0;
    int n_logs = 0;
    int n_queries = 0;
    int n_results = 0;
    int n_cfg = 0;

    byte_histogram_vowel_stats dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_byte_value     (i_byte_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_bin_count      (o_bin_count),
        .o_total_count    (o_total_count),
        .o_vowel_count    (o_vowel_count),
        .o_vowel_fraction (o_vowel_fraction)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("timeout with %0d results outstanding", pending_stats.size());
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic plain_vowel(input logic [7:0] b);
        case (b)
            CH_A_LO, CH_A_UP, CH_E_LO, CH_E_UP, CH_I_LO,
            CH_I_UP, CH_O_LO, CH_O_UP, CH_U_LO, CH_U_UP: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // applies one item to the mirror and returns the stats it should report
    function automatic t_stats tally_byte(input logic op, input logic [7:0] b);
        t_stats s;
        logic [CNT_W:0] vsum;
        logic [CNT_W+FRAC_BITS-1:0] quot;
        if (op == OP_LOG) begin
            hist_bins[b] = bump(hist_bins[b]);
            hist_total = bump(hist_total);
            if (plain_vowel(b))
                hist_plain = bump(hist_plain);
            else if (b == CH_Y_LO || b == CH_Y_UP)
                hist_ylet = bump(hist_ylet);
        end
        vsum = {1'b0, hist_plain};
        if (hist_incl_y)
            vsum = vsum + {1'b0, hist_ylet};
        s.bin = hist_bins[b];
        s.total = hist_total;
        s.vowels = vsum[CNT_W] ? CNT_MAX : vsum[CNT_W-1:0];
        if (hist_total == '0) begin
            s.frac = '0;
        end else if (s.vowels >= hist_total) begin
            s.frac = FRAC_ONE;
        end else begin
            quot = {s.vowels, {FRAC_BITS{1'b0}}} / {{FRAC_BITS{1'b0}}, hist_total};
            s.frac = quot[FRAC_W-1:0];
        end
        return s;
    endfunction

    function automatic t_dir_row item_row(input logic op, input logic [7:0] b);
        t_dir_row r;
        r.kind = ROW_ITEM;
        r.op = op;
        r.byte_val = b;
        r.cfg_val = 1'b0;
        r.typed = '0;
        return r;
    endfunction

    function automatic t_dir_row checked_row(input logic op, input logic [7:0] b,
                                             input logic [CNT_W-1:0] bin,
                                             input logic [CNT_W-1:0] total,
                                             input logic [CNT_W-1:0] vowels,
                                             input logic [FRAC_W-1:0] frac);
        t_dir_row r;
        r = item_row(op, b);
        r.kind = ROW_CHECKED;
        r.typed = '{bin: bin, total: total, vowels: vowels, frac: frac};
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic v);
        t_dir_row r;
        r = item_row(OP_QUERY, 8'h00);
        r.kind = ROW_CFG;
        r.cfg_val = v;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one command beat; start stays high when the next beat follows directly
    task automatic send_byte(input logic op, input logic [7:0] b, input bit use_typed,
                             input t_stats typed, input int gap);
        t_stats predicted;
        start <= 1'b1;
        i_op <= op;
        i_byte_value <= b;
        do @(posedge i_clk); while (busy);
        predicted = tally_byte(op, b);
        pending_stats.push_back(use_typed ? typed : predicted);
        if (op == OP_LOG)
            n_logs++;
        else
            n_queries++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_stats.size() != 0 || busy)
            @(posedge i_clk);
    endtask

    task automatic write_incl_y(input logic v);
        wait_drained();
        repeat (3) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        hist_incl_y = v;
        n_cfg++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] exp_v,
                               input logic [CNT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_cnt++;
            error_cnt++;
            if (mismatch_cnt <= 10)
                $display("mismatch at result %0d on %s: expected %0d, got %0d",
                         n_results, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_stats exp_s;
        if (i_rst_n && o_result_valid) begin
            if (pending_stats.size() == 0) begin
                error_cnt++;
                $display("result beat with nothing expected: bin %0d total %0d",
                         o_bin_count, o_total_count);
            end else begin
                exp_s = pending_stats.pop_front();
                check_field("bin_count", exp_s.bin, o_bin_count);
                check_field("total_count", exp_s.total, o_total_count);
                check_field("vowel_count", exp_s.vowels, o_vowel_count);
                check_field("vowel_fraction", CNT_W'(exp_s.frac), CNT_W'(o_vowel_fraction));
            end
            n_results++;
        end
    end

    initial begin
        t_dir_row row;
        int gap_on;
        int drain_at;
        int pick;
        logic op;
        logic [7:0] b;

        vowel_chars = '{CH_A_LO, CH_A_UP, CH_E_LO, CH_E_UP, CH_I_LO, CH_I_UP,
                        CH_O_LO, CH_O_UP, CH_U_LO, CH_U_UP, CH_Y_LO, CH_Y_UP};
        for (int i = 0; i < BIN_N; i++)
            hist_bins[i] = '0;
        hist_total = '0;
        hist_plain = '0;
        hist_ylet = '0;
        hist_incl_y = 1'b0;

        // empty log, bin extremes, every vowel in both cases, y on and off
        dir_rows.push_back(checked_row(OP_QUERY, 8'h00, 0, 0, 0, 0));
        dir_rows.push_back(checked_row(OP_QUERY, 8'hff, 0, 0, 0, 0));
        dir_rows.push_back(checked_row(OP_LOG, CH_A_LO, 1, 1, 1, FRAC_ONE));
        dir_rows.push_back(checked_row(OP_LOG, CH_Y_LO, 1, 2, 1, FRAC_ONE >> 1));
        dir_rows.push_back(item_row(OP_LOG, 8'h00));
        dir_rows.push_back(item_row(OP_LOG, 8'hff));
        for (int i = 1; i < 10; i++)
            dir_rows.push_back(item_row(OP_LOG, vowel_chars[i]));
        dir_rows.push_back(item_row(OP_LOG, CH_Y_UP));
        dir_rows.push_back(item_row(OP_QUERY, CH_Y_LO));
        dir_rows.push_back(cfg_row(1'b1));
        dir_rows.push_back(item_row(OP_QUERY, CH_Y_LO));
        dir_rows.push_back(item_row(OP_LOG, CH_Y_LO));
        dir_rows.push_back(item_row(OP_LOG, 8'h80));
        dir_rows.push_back(item_row(OP_LOG, 8'h7f));
        dir_rows.push_back(item_row(OP_QUERY, 8'h00));
        dir_rows.push_back(cfg_row(1'b0));
        dir_rows.push_back(item_row(OP_QUERY, 8'hff));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
                write_incl_y(row.cfg_val);
            else
                send_byte(row.op, row.byte_val, row.kind == ROW_CHECKED, row.typed,
                          $urandom_range(0, 2));
        end

        for (int p = 0; p < PHASES; p++) begin
            write_incl_y(p[0] ? 1'b0 : 1'b1);
            gap_on = (p != 2);
            drain_at = $urandom_range(20, PHASE_ITEMS - 20);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // hold off until everything in flight has come back
                if (k == drain_at) begin
                    wait_drained();
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    b = vowel_chars[$urandom_range(0, 11)];
                else if (pick < 6)
                    b = 8'($urandom_range(8'h41, 8'h7a));
                else
                    b = 8'($urandom_range(0, 255));
                op = ($urandom_range(0, 99) < 30) ? OP_QUERY : OP_LOG;
                send_byte(op, b, 1'b0, '0, gap_on ? pick_gap() : 0);
            end
        end

        wait_drained();
        repeat (MAX_LATENCY + 5) @(posedge i_clk);
        if (pending_stats.size() != 0) begin
            error_cnt++;
            $display("%0d expected results never arrived", pending_stats.size());
        end
        $display("ran %0d logged bytes and %0d bin queries, %0d result beats checked",
                 n_logs, n_queries, n_results);
        $display("include_y written %0d times across both settings, %0d mismatches",
                 n_cfg, mismatch_cnt);
        if (error_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[byte_histogram_vowel_stats.f]
sv/hbvs_pkg.sv
sv/hbvs_ram.sv
sv/byte_histogram_vowel_stats.sv
sv/hbvs_chk.sv
dv/tb_top.sv
